@@ rtl/lrukv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity after reset, and the value returned on a miss
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Request operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Lookup summary passed from the match logic to the update logic
  typedef struct packed {
    logic hit;         // a valid entry holds the key
    logic lru_found;   // a least recent entry was located
    logic free_found;  // an empty slot exists
  } lkup_status_t;

endpackage

`default_nettype wire

@@ rtl/lrukv_lookup.sv @@
// Parallel key match, least recent entry search and free slot search.
`timescale 1ns / 1ps
`default_nettype none

module lrukv_lookup
  import lrukv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic [KEY_W-1:0]                       key_i,
  input  wire logic [ENTRIES-1:0][KEY_W-1:0]          keys_i,
  input  wire logic [ENTRIES-1:0]                     valid_i,
  input  wire logic [ENTRIES-1:0][((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ranks_i,
  input  wire logic [$clog2(ENTRIES + 1)-1:0]         occ_i,
  output logic      [ENTRIES-1:0]                     match_o,
  output logic      [ENTRIES-1:0]                     lru_o,
  output logic      [ENTRIES-1:0]                     free_o,
  output lkup_status_t                                status_o
);

  localparam int OCC_W = $clog2(ENTRIES + 1);

  logic [OCC_W-1:0] occ_last;

  // Ranks of valid entries form 0..occ-1, so the least recent one holds occ-1
  assign occ_last = occ_i - OCC_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i] = valid_i[i] && (keys_i[i] == key_i);
      lru_o[i]   = valid_i[i] && (OCC_W'(ranks_i[i]) == occ_last);
    end
  end

  // Lowest empty slot: lowest zero bit of the valid vector
  assign free_o = ~valid_i & (valid_i + ENTRIES'(1));

  assign status_o.hit        = |match_o;
  assign status_o.lru_found  = |lru_o;
  assign status_o.free_found = |free_o;

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache of ENTRIES entries with least recently
// used replacement. A request (get or put) is taken into an input register,
// and while it is held there the key is compared against every entry at
// once; the entry state is updated and a get result is loaded into the
// result register at the end of the cycle in which the request leaves the
// input register, which a get can only do once the result register has room.
// One request is accepted per cycle while no get waits in the input register;
// the single pass from input register to result register sets that figure,
// and only a get whose result register is still held by a stalled result
// waits. Puts give no result. The capacity register (1..ENTRIES, values
// outside clamp) may be written only while the cache is idle; lowering it
// below the current fill drops nothing, later inserts evict instead.
module lru_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CAP_W-1:0]         cfg_data_i,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     operation_i,
  input  wire logic signed [KEY_W-1:0]  key_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          found_o,
  output logic signed [VAL_W-1:0]       read_value_o
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Configuration
  logic [CAP_W-1:0] capacity_q;

  // Input register
  logic             s1_valid_q, s1_valid_d;
  op_e              s1_op_q;
  logic [KEY_W-1:0] s1_key_q;
  logic [VAL_W-1:0] s1_value_q;

  // Entry store
  logic [ENTRIES-1:0][KEY_W-1:0]  keys_q, keys_d;
  logic [ENTRIES-1:0][VAL_W-1:0]  values_q, values_d;
  logic [ENTRIES-1:0][RANK_W-1:0] ranks_q, ranks_d;
  logic [ENTRIES-1:0]             valid_q, valid_d;
  logic [OCC_W-1:0]               occ_q, occ_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic             found_q;
  logic [VAL_W-1:0] read_value_q;

  // Lookup results
  logic [ENTRIES-1:0] match, lru, free, sel;
  lkup_status_t       status;
  logic [RANK_W-1:0]  sel_rank;
  logic [VAL_W-1:0]   hit_value;

  logic             in_accept, retire, proc, is_put, full, insert, promote;
  logic [CMP_W-1:0] cap_ext, eff_cap;

  // Configuration port is always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Handshake: a put always retires, a get needs room in the result register
  assign is_put     = (s1_op_q == OP_PUT);
  assign retire     = is_put || !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && retire;
  assign in_stall_o = s1_valid_q && !retire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= op_e'(operation_i);
      s1_key_q   <= key_i;
      s1_value_q <= value_i;
    end
  end

  // Parallel lookup
  lrukv_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .key_i    (s1_key_q),
    .keys_i   (keys_q),
    .valid_i  (valid_q),
    .ranks_i  (ranks_q),
    .occ_i    (occ_q),
    .match_o  (match),
    .lru_o    (lru),
    .free_o   (free),
    .status_o (status)
  );

  // Effective capacity, clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full    = CMP_W'(occ_q) >= eff_cap;
  assign insert  = is_put && !status.hit && !full;
  assign promote = proc && (status.hit || is_put);

  // Target slot: the hit entry, else the least recent when full, else a free one
  always_comb begin
    priority if (status.hit) begin
      sel = match;
    end else if (full) begin
      sel = lru;
    end else begin
      sel = free;
    end
  end

  // One-hot selection of the target rank and the hit value
  always_comb begin
    sel_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_rank  = sel_rank | (ranks_q[i] & {RANK_W{sel[i]}});
      hit_value = hit_value | (values_q[i] & {VAL_W{match[i]}});
    end
  end

  // Entry update: write on put, move target to rank 0 and age the more recent
  always_comb begin
    keys_d   = keys_q;
    values_d = values_q;
    ranks_d  = ranks_q;
    valid_d  = valid_q;
    for (int i = 0; i < ENTRIES; i++) begin
      if (proc && is_put && sel[i]) begin
        keys_d[i]   = s1_key_q;
        values_d[i] = s1_value_q;
      end
      if (proc && insert && sel[i]) begin
        valid_d[i] = 1'b1;
      end
      if (promote) begin
        if (sel[i]) begin
          ranks_d[i] = '0;
        end else if (valid_q[i] && (insert || ranks_q[i] < sel_rank)) begin
          ranks_d[i] = ranks_q[i] + RANK_W'(1);
        end
      end
    end
    occ_d = occ_q + OCC_W'(proc && insert);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q   <= keys_d;
    values_q <= values_d;
    ranks_q  <= ranks_d;
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && !is_put) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && !is_put) begin
      found_q      <= status.hit;
      read_value_q <= status.hit ? hit_value : MISS_VALUE;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  // Checks
  a_occ_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match the number of valid entries");

  a_key_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(match))
    else $error("key matches more than one entry");

  a_evict_lru : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_put && !status.hit && full) |-> status.lru_found)
    else $error("eviction without a least recent entry");

  a_insert_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && insert) |-> status.free_found)
    else $error("insert without a free slot");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the LRU key/value cache: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import lrukv_pkg::*;

  localparam int N_ENTRIES      = 16;
  localparam int POOL_SIZE      = 24;
  localparam int ITEMS_PER_PH   = 100;
  localparam int N_PHASES       = 10;
  localparam int PIPE_SETTLE    = 4;    // request register plus result register, with margin
  localparam int HOLD_OFF       = 64;   // long receiver stall used to back up the pipeline
  localparam int WATCHDOG_LIMIT = 2000;

  // Directed table row kinds
  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;     // capacity on a configuration row
    logic             chk;     // expected result typed in below
    logic             found;
    logic [VAL_W-1:0] rvalue;
  } dir_row_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] rvalue;
  } lookup_result_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // DUT ports
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             operation_i;
  logic [KEY_W-1:0] key_i;
  logic [VAL_W-1:0] value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             found_o;
  logic [VAL_W-1:0] read_value_o;

  lru_key_value_cache #(
    .ENTRIES(N_ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

  // Typed expectation travelling alongside the request payload
  logic             drv_chk;
  logic             drv_found;
  logic [VAL_W-1:0] drv_rvalue;

  // Traffic shaping shared between the stimulus and the receiver
  bit tx_burst;
  bit rx_burst;
  bit rx_hold_req;

  // Shadow cache state
  logic [KEY_W-1:0] ent_key   [N_ENTRIES];
  logic [VAL_W-1:0] ent_val   [N_ENTRIES];
  bit               ent_valid [N_ENTRIES];
  int unsigned      ent_rank  [N_ENTRIES];
  int unsigned      shadow_occupancy;
  logic [CAP_W-1:0] shadow_capacity;

  lookup_result_t pending_lookups[$];
  dir_row_t       dir_rows[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int n_errors;
  int n_results;
  int n_gets;
  int n_puts;
  int n_hits;
  int n_misses;
  int n_evictions;
  int n_cfg_writes;
  int quiet_cycles;

  // One line per mismatch, and a count
  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("%0t ERROR result %0d: %s got %h expected %h", $realtime, n_results, what, got,
             want);
    n_errors++;
  endtask

  // Move an entry to rank 0; valid entries more recent than limit age by one
  task automatic promote_entry(input int slot, input int unsigned limit);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (ent_valid[i] && i != slot && ent_rank[i] < limit) ent_rank[i]++;
    end
    ent_rank[slot] = 0;
  endtask

  // Apply one request to the shadow cache and work out the lookup result
  task automatic lru_update(input op_e op, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, output bit gives,
                            output lookup_result_t res);
    int          hit;
    int          slot;
    int          victim;
    int unsigned eff_cap;
    int unsigned best_rank;
    bit          any;
    hit = -1;
    for (int i = N_ENTRIES - 1; i >= 0; i--) begin
      if (ent_valid[i] && ent_key[i] == k) hit = i;
    end
    gives      = (op == OP_GET);
    res.found  = 1'b0;
    res.rvalue = MISS_VALUE;
    if (op == OP_GET) begin
      if (hit >= 0) begin
        res.found  = 1'b1;
        res.rvalue = ent_val[hit];
        promote_entry(hit, ent_rank[hit]);
        n_hits++;
      end else begin
        n_misses++;
      end
    end else if (hit >= 0) begin
      // update in place, never evicts
      ent_val[hit] = v;
      promote_entry(hit, ent_rank[hit]);
    end else begin
      slot = -1;
      for (int i = N_ENTRIES - 1; i >= 0; i--) begin
        if (!ent_valid[i]) slot = i;
      end
      eff_cap = shadow_capacity;
      if (eff_cap < 1) eff_cap = 1;
      if (eff_cap > N_ENTRIES) eff_cap = N_ENTRIES;
      if (shadow_occupancy >= eff_cap || slot < 0) begin
        // replace the least recent entry; first one wins a tie
        victim    = 0;
        best_rank = 0;
        any       = 1'b0;
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (ent_valid[i] && (!any || ent_rank[i] > best_rank)) begin
            victim    = i;
            best_rank = ent_rank[i];
            any       = 1'b1;
          end
        end
        ent_key[victim] = k;
        ent_val[victim] = v;
        promote_entry(victim, ent_rank[victim]);
        n_evictions++;
      end else begin
        ent_valid[slot] = 1'b1;
        ent_key[slot]   = k;
        ent_val[slot]   = v;
        promote_entry(slot, N_ENTRIES);
        shadow_occupancy++;
      end
    end
  endtask

  // Scoreboard: check results first, then predict from newly taken requests
  always @(posedge clk_i) begin : scoreboard
    lookup_result_t want;
    lookup_result_t predicted;
    bit             gives;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("unexpected result, read_value", read_value_o, MISS_VALUE);
        end else begin
          want = pending_lookups.pop_front();
          if (found_o !== want.found)
            report_mismatch("found", {31'b0, found_o}, {31'b0, want.found});
          if (read_value_o !== want.rvalue)
            report_mismatch("read_value", read_value_o, want.rvalue);
        end
        n_results++;
      end
      if (in_valid_i && !in_stall_o) begin
        lru_update(op_e'(operation_i), key_i, value_i, gives, predicted);
        if (operation_i == OP_GET) n_gets++;
        else n_puts++;
        if (gives) begin
          if (drv_chk) pending_lookups.push_back({drv_found, drv_rvalue});
          else pending_lookups.push_back(predicted);
        end
      end
    end
  end

  // Watchdog on cycles in which no handshake completes
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("lru_key_value_cache: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stall before each result outside burst phases, plus one long hold-off on request
  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(negedge clk_i);
      end
      n = rx_burst ? 0 : $urandom_range(0, 8);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  // Offer one request after a random gap (none in burst mode); returns on the falling edge after it is taken
  task automatic send_request(input op_e op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v, input logic chk,
                              input logic f, input logic [VAL_W-1:0] rv);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    drv_chk     <= chk;
    drv_found   <= f;
    drv_rvalue  <= rv;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every lookup has returned and the pipe is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_capacity = c;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic dir_row_t req_row(input op_e op, input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v, input logic chk,
                                       input logic f, input logic [VAL_W-1:0] rv);
    return '{kind: ROW_REQ, op: op, key: k, val: v, chk: chk, found: f, rvalue: rv};
  endfunction

  function automatic dir_row_t cfg_row(input logic [CAP_W-1:0] c);
    return '{kind: ROW_CFG, op: OP_GET, key: '0, val: {27'b0, c}, chk: 1'b0,
             found: 1'b0, rvalue: '0};
  endfunction

  initial begin : stimulus
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] k;
    op_e              op;
    dir_row_t         row;

    // known values on every input from time zero
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_GET;
    key_i       = '0;
    value_i     = '0;
    drv_chk     = 1'b0;
    drv_found   = 1'b0;
    drv_rvalue  = '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    rx_hold_req = 1'b0;
    quiet_cycles = 0;

    // shadow state after reset
    for (int i = 0; i < N_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_val[i]   = '0;
      ent_rank[i]  = 0;
    end
    shadow_occupancy = 0;
    shadow_capacity  = CAP_RESET;

    // key pool: extremes plus random keys, so lookups hit often
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed rows: empty cache, extreme keys and values, key -1, in-place update,
    // capacity lowered below fill, capacity zero and capacity above the entry count
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, MISS_VALUE));
    dir_rows.push_back(req_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, MISS_VALUE));
    dir_rows.push_back(req_row(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 32'h7FFF_FFFF));
    dir_rows.push_back(req_row(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h8000_0000));
    dir_rows.push_back(req_row(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h0000_0000));
    dir_rows.push_back(req_row(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(req_row(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h1234_5678, 32'h0, 1'b1, 1'b0, MISS_VALUE));
    dir_rows.push_back(cfg_row(5'd2));
    dir_rows.push_back(req_row(OP_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0005, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(req_row(OP_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_PUT, 32'h0000_0007, 32'h0000_0077, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0006, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0007, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(req_row(OP_PUT, 32'h0000_0008, 32'h0000_0088, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0008, 32'h0, 1'b0, 1'b0, '0));
    dir_rows.push_back(req_row(OP_GET, 32'h0000_0007, 32'h0, 1'b0, 1'b0, '0));

    // reset
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_capacity(row.val[CAP_W-1:0]);
      end else begin
        send_request(row.op, row.key, row.val, row.chk, row.found, row.rvalue);
      end
    end

    // random phases, each under its own capacity
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       cap = 5'd16;
        1:       cap = 5'd3;
        2:       cap = 5'd12;
        3:       cap = 5'd1;
        4:       cap = 5'd0;
        5:       cap = 5'd31;
        6:       cap = 5'd17;
        7:       cap = 5'd2;
        8:       cap = 5'd8;
        default: cap = 5'd16;
      endcase
      // sender pauses here until every lookup is back
      wait_idle();
      write_capacity(cap);
      tx_burst = (ph == 2 || ph == 6 || ph == 9);
      rx_burst = (ph == 4 || ph == 8);
      // back-to-back traffic into a long receiver hold-off
      if (ph == 2) rx_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        op = op_e'($urandom_range(0, 1));
        k  = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
        send_request(op, k, $urandom, 1'b0, 1'b0, '0);
      end
    end

    wait_idle();

    $display("Covered %0d requests: %0d gets (%0d hits, %0d misses), %0d puts, %0d evictions",
             n_gets + n_puts, n_gets, n_hits, n_misses, n_puts, n_evictions);
    $display("Capacity written %0d times (0, 1, 2, 16, 17, 31 among them), with a %0d-cycle hold-off",
             n_cfg_writes, HOLD_OFF);
    if (pending_lookups.size() != 0)
      report_mismatch("lookups never returned, count", pending_lookups.size(), 0);
    if (n_errors == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

endmodule
